@@ hw/rtl/smrg_pkg.sv @@
// Shared types and constants for the sphere merge block.
`default_nettype none
package smrg_pkg;

  localparam int SqrtBits = 34;
  localparam int DivBits  = 33;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;

  typedef enum logic [1:0] {
    CASE_MERGED = 2'd0,
    CASE_FIRST  = 2'd1,
    CASE_SECOND = 2'd2
  } merge_case_t;

  typedef struct packed {
    logic [2:0][31:0] c1;
    logic [30:0]      r1;
    logic [2:0][31:0] c2;
    logic [30:0]      r2;
  } pair_t;

  typedef struct packed {
    logic [2:0][31:0] c1;
    logic [2:0][31:0] c2;
    logic [30:0]      r1;
    logic [30:0]      r2;
    logic [2:0][32:0] mag;
    logic [2:0]       neg;
  } info_t;

  typedef struct packed {
    logic [2:0][31:0] base;
    logic [30:0]      radius;
    merge_case_t      mcase;
    logic [2:0][32:0] mag;
    logic [2:0]       neg;
    logic [33:0]      len;
    logic [33:0]      tval;
  } job_t;

endpackage
`default_nettype wire

@@ hw/rtl/smrg_front.sv @@
// Front part: centre distance, square root and merge classification.
`default_nettype none
module smrg_front import smrg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire pair_t in_pair,
  input  wire logic  q_full,
  output logic       push,
  output job_t       push_job
);

  logic en;

  logic             v0_r, v1_r, v2_r;
  info_t            info0_r, info1_r;
  logic [2:0][65:0] sq1_r;
  info_t            info0_nxt;

  logic [SqrtBits:0] sv_r;
  logic [66:0]       srem_r [0:SqrtBits];
  logic [33:0]       sres_r [0:SqrtBits];
  info_t             sinfo_r [0:SqrtBits];

  logic cls_v_r;
  job_t cls_r, cls_nxt;

  assign en       = !cls_v_r || !q_full;
  assign in_ready = en;
  assign push     = cls_v_r && !q_full;
  assign push_job = cls_r;

  always_comb begin
    logic [32:0] d;
    info0_nxt.c1 = in_pair.c1;
    info0_nxt.c2 = in_pair.c2;
    info0_nxt.r1 = in_pair.r1;
    info0_nxt.r2 = in_pair.r2;
    for (int i = 0; i < 3; i++) begin
      d = {in_pair.c2[i][31], in_pair.c2[i]} - {in_pair.c1[i][31], in_pair.c1[i]};
      info0_nxt.neg[i] = d[32];
      info0_nxt.mag[i] = d[32] ? (33'd0 - d) : d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info0_r <= info0_nxt;
      info1_r <= info0_r;
      for (int i = 0; i < 3; i++) begin
        sq1_r[i] <= {33'd0, info0_r.mag[i]} * {33'd0, info0_r.mag[i]};
      end
      srem_r[0]  <= {1'b0, sq1_r[0]} + {1'b0, sq1_r[1]} + {1'b0, sq1_r[2]};
      sres_r[0]  <= '0;
      sinfo_r[0] <= info1_r;
    end
  end

  assign sv_r[0] = v2_r;

  genvar k;
  generate
    for (k = 0; k < SqrtBits; k++) begin : g_sqrt
      localparam int B = SqrtBits - 1 - k;
      logic        v_r;
      logic [66:0] trial;
      assign trial = ({33'd0, sres_r[k]} << (B + 1)) | (67'd1 << (2 * B));
      assign sv_r[k+1] = v_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r <= 1'b0;
        end else if (en) begin
          v_r <= sv_r[k];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sinfo_r[k+1] <= sinfo_r[k];
          if (srem_r[k] >= trial) begin
            srem_r[k+1] <= srem_r[k] - trial;
            sres_r[k+1] <= sres_r[k] | (34'd1 << B);
          end else begin
            srem_r[k+1] <= srem_r[k];
            sres_r[k+1] <= sres_r[k];
          end
        end
      end
    end
  endgenerate

  always_comb begin
    info_t       inf;
    logic [33:0] len;
    logic [35:0] len36, r1s, r2s;
    logic        first, second;
    logic [34:0] radsum;
    logic [33:0] rad;
    inf    = sinfo_r[SqrtBits];
    len    = sres_r[SqrtBits];
    len36  = {2'b0, len};
    r1s    = {5'b0, inf.r1};
    r2s    = {5'b0, inf.r2};
    first  = $signed(r1s - r2s) >= $signed(len36);
    second = $signed(r2s - r1s) >= $signed(len36);
    radsum = {1'b0, len} + {4'b0, inf.r1} + {4'b0, inf.r2};
    rad    = radsum[34:1];
    cls_nxt.mag  = inf.mag;
    cls_nxt.neg  = inf.neg;
    cls_nxt.len  = len;
    cls_nxt.tval = rad - {3'b0, inf.r1};
    if (first) begin
      cls_nxt.base   = inf.c1;
      cls_nxt.radius = inf.r1;
      cls_nxt.mcase  = CASE_FIRST;
    end else if (second) begin
      cls_nxt.base   = inf.c2;
      cls_nxt.radius = inf.r2;
      cls_nxt.mcase  = CASE_SECOND;
    end else begin
      cls_nxt.base   = inf.c1;
      cls_nxt.radius = (rad[33:31] != 3'd0) ? 31'h7FFFFFFF : rad[30:0];
      cls_nxt.mcase  = CASE_MERGED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_v_r <= 1'b0;
    end else if (en) begin
      cls_v_r <= sv_r[SqrtBits];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r <= cls_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/smrg_queue.sv @@
// Short job queue between the front and back parts.
`default_nettype none
module smrg_queue import smrg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      pop_job
);

  job_t               mem_r [0:QueueDepth-1];
  logic [QueueAw-1:0] wr_r, rd_r;
  logic [QueueAw:0]   cnt_r;

  assign full    = cnt_r == (QueueAw+1)'(QueueDepth);
  assign empty   = cnt_r == '0;
  assign pop_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

endmodule
`default_nettype wire

@@ hw/rtl/smrg_back.sv @@
// Back part: centre offset product, pipelined divide and output register.
`default_nettype none
module smrg_back import smrg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  output logic       pop,
  input  wire job_t  pop_job,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [2:0][31:0] out_center,
  output logic [30:0]      out_radius,
  output merge_case_t      out_case
);

  logic en;
  logic out_v_r;

  logic [DivBits:0]      dv_r;
  logic [2:0][33:0]      drem_r [0:DivBits];
  logic [2:0][32:0]      dlow_r [0:DivBits];
  logic [2:0][32:0]      dq_r   [0:DivBits];
  job_t                  djob_r [0:DivBits];

  logic [2:0][31:0] oc_r, oc_nxt;
  logic [30:0]      orad_r;
  merge_case_t      ocase_r;

  assign en  = !out_v_r || out_ready;
  assign pop = !q_empty && en;

  always_ff @(posedge clk) begin
    logic [66:0] p;
    if (en) begin
      djob_r[0] <= pop_job;
      for (int i = 0; i < 3; i++) begin
        p = {34'd0, pop_job.mag[i]} * {33'd0, pop_job.tval};
        drem_r[0][i] <= p[66:33];
        dlow_r[0][i] <= p[32:0];
        dq_r[0][i]   <= '0;
      end
    end
  end

  logic mv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= pop;
    end
  end
  assign dv_r[0] = mv_r;

  genvar k;
  generate
    for (k = 0; k < DivBits; k++) begin : g_div
      logic v_r;
      assign dv_r[k+1] = v_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r <= 1'b0;
        end else if (en) begin
          v_r <= dv_r[k];
        end
      end
      always_ff @(posedge clk) begin
        logic [34:0] r2;
        logic        ge;
        if (en) begin
          djob_r[k+1] <= djob_r[k];
          for (int i = 0; i < 3; i++) begin
            r2 = {drem_r[k][i], dlow_r[k][i][32]};
            ge = r2 >= {1'b0, djob_r[k].len};
            drem_r[k+1][i] <= ge ? 34'(r2 - {1'b0, djob_r[k].len}) : r2[33:0];
            dlow_r[k+1][i] <= {dlow_r[k][i][31:0], 1'b0};
            dq_r[k+1][i]   <= {dq_r[k][i][31:0], ge};
          end
        end
      end
    end
  endgenerate

  always_comb begin
    job_t        j;
    logic [34:0] off, sum;
    j = djob_r[DivBits];
    for (int i = 0; i < 3; i++) begin
      off = j.neg[i] ? (35'd0 - {2'b0, dq_r[DivBits][i]}) : {2'b0, dq_r[DivBits][i]};
      sum = {{3{j.base[i][31]}}, j.base[i]} + off;
      if (j.mcase != CASE_MERGED) oc_nxt[i] = j.base[i];
      else if (!sum[34] && sum[33:31] != 3'd0) oc_nxt[i] = 32'h7FFFFFFF;
      else if (sum[34] && sum[33:31] != 3'b111) oc_nxt[i] = 32'h80000000;
      else oc_nxt[i] = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_r[DivBits];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oc_r    <= oc_nxt;
      orad_r  <= djob_r[DivBits].radius;
      ocase_r <= djob_r[DivBits].mcase;
    end
  end

  assign out_valid  = out_v_r;
  assign out_center = oc_r;
  assign out_radius = orad_r;
  assign out_case   = ocase_r;

endmodule
`default_nettype wire

@@ hw/rtl/sphere_merge.sv @@
// Top level of the bounding sphere merge block.
//
//  channel  | ports                     | payload
//  ---------+---------------------------+----------------------------------------
//  input    | in_tvalid/tready/tdata    | two spheres, 254 bits in 256
//  result   | out_tvalid/tready/tdata/  | merged sphere, 127 bits in 128;
//           | tuser                     | tuser holds merge_case
//
// One transfer per cycle in each direction while neither side stalls; the front
// holds the 34-stage square root and the back the 33-stage divide.
// A four-entry queue parts front and back; each stalls only when the next
// part is full. Reset is synchronous, active low, and empties all stages.
`default_nettype none
module sphere_merge import smrg_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // first_center_x/y/z, first_radius, second_center_x/y/z, second_radius
  input  wire logic [255:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // merged_center_x/y/z, merged_radius, zero pad
  output logic [127:0]      out_tdata,
  // merge_case
  output logic [1:0]        out_tuser
);

  pair_t            pair;
  logic             push, q_full, q_empty, pop;
  job_t             push_job, pop_job;
  logic [2:0][31:0] center;
  logic [30:0]      radius;
  merge_case_t      mcase;

  assign pair.c1[0] = in_tdata[31:0];
  assign pair.c1[1] = in_tdata[63:32];
  assign pair.c1[2] = in_tdata[95:64];
  assign pair.r1    = in_tdata[126:96];
  assign pair.c2[0] = in_tdata[158:127];
  assign pair.c2[1] = in_tdata[190:159];
  assign pair.c2[2] = in_tdata[222:191];
  assign pair.r2    = in_tdata[253:223];

  smrg_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pair  (pair),
    .q_full,
    .push,
    .push_job
  );

  smrg_queue u_queue (
    .clk, .rst_n,
    .push, .push_job,
    .full    (q_full),
    .pop,
    .empty   (q_empty),
    .pop_job
  );

  smrg_back u_back (
    .clk, .rst_n,
    .q_empty,
    .pop,
    .pop_job,
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_center (center),
    .out_radius (radius),
    .out_case   (mcase)
  );

  assign out_tdata = {1'b0, radius, center[2], center[1], center[0]};
  assign out_tuser = mcase;

endmodule
`default_nettype wire

@@ hw/rtl/smrg_checker.sv @@
// Port checker for the sphere merge block, bound to the top level.
`default_nettype none
module smrg_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic [1:0]   out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_case_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("bad merge case");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[127])
    else $error("pad bit set");

endmodule

bind sphere_merge smrg_checker u_chk (.*);
`default_nettype wire

@@ sim/sphere_merge_test.sv @@
// Self-checking testbench for the bounding sphere merge block.
`default_nettype none
module sphere_merge_test;
  import smrg_pkg::*;

  typedef struct {
    logic signed [31:0] c1 [3];
    logic [30:0]        r1;
    logic signed [31:0] c2 [3];
    logic [30:0]        r2;
  } sphere_pair_t;

  typedef struct {
    logic [31:0] c [3];
    logic [30:0] r;
    merge_case_t mcase;
  } merged_sphere_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [1:0]   out_tuser;

  sphere_pair_t   pending_pairs [$];
  merged_sphere_t merged_expected [$];
  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;

  sphere_merge dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #6 clk = ~clk;

  function automatic merged_sphere_t merge_spheres(sphere_pair_t p);
    merged_sphere_t m;
    logic signed [32:0]  d [3];
    logic [32:0]         mag [3];
    logic [65:0]         sq;
    logic [67:0]         tst;
    logic [33:0]         len;
    logic signed [40:0]  r1, r2, l, mn, mx, rad, t;
    logic [67:0]         prod;
    logic [67:0]         q;
    logic signed [40:0]  cen;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({p.c2[i][31], p.c2[i]}) - $signed({p.c1[i][31], p.c1[i]});
      mag[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      sq += 66'(mag[i]) * 66'(mag[i]);
    end
    len = '0;
    for (int b = 33; b >= 0; b--) begin
      tst = 68'(len | (34'd1 << b));
      if (tst * tst <= 68'(sq)) len = len | (34'd1 << b);
    end
    r1 = 41'(p.r1);
    r2 = 41'(p.r2);
    l  = 41'(len);
    if (r1 - r2 >= l) begin
      m.c = '{p.c1[0], p.c1[1], p.c1[2]};
      m.r = p.r1;
      m.mcase = CASE_FIRST;
      return m;
    end
    if (r2 - r1 >= l) begin
      m.c = '{p.c2[0], p.c2[1], p.c2[2]};
      m.r = p.r2;
      m.mcase = CASE_SECOND;
      return m;
    end
    mn = (-r1 < l - r2) ? -r1 : l - r2;
    mx = (r1 > l + r2) ? r1 : l + r2;
    rad = (mx - mn) >>> 1;
    t = rad + mn;
    for (int i = 0; i < 3; i++) begin
      prod = 68'(mag[i]) * 68'(t);
      q = prod / 68'(len);
      cen = $signed({{9{p.c1[i][31]}}, p.c1[i]}) +
            (d[i][32] ? -$signed(41'(q)) : $signed(41'(q)));
      if (cen > 41'sd2147483647) m.c[i] = 32'h7fffffff;
      else if (cen < -41'sd2147483648) m.c[i] = 32'h80000000;
      else m.c[i] = cen[31:0];
    end
    m.r = (rad > 41'sd2147483647) ? 31'h7fffffff : rad[30:0];
    m.mcase = CASE_MERGED;
    return m;
  endfunction

  function automatic logic [255:0] pack_pair(sphere_pair_t p);
    return {2'b0, p.r2, p.c2[2], p.c2[1], p.c2[0], p.r1, p.c1[2], p.c1[1], p.c1[0]};
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    fail_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        sphere_pair_t p;
        p = pending_pairs.pop_front();
        merged_expected.push_back(merge_spheres(p));
        in_tdata <= pack_pair(p);
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (merged_expected.size() == 0) begin
          $display("unexpected result transfer %h", out_tdata);
          fail_count++;
        end else begin
          merged_sphere_t m;
          m = merged_expected.pop_front();
          for (int i = 0; i < 3; i++)
            if (out_tdata[32*i +: 32] !== m.c[i])
              report_mismatch($sformatf("merged_center[%0d]", i), out_tdata[32*i +: 32], m.c[i]);
          if (out_tdata[126:96] !== m.r) report_mismatch("merged_radius", out_tdata[126:96], m.r);
          if (out_tuser !== m.mcase) report_mismatch("merge_case", out_tuser, m.mcase);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return 32'($signed($urandom_range(400)) - 200) <<< 16;
    endcase
  endfunction

  task automatic add_pair(logic [31:0] a0, a1, a2, logic [30:0] ra,
                          logic [31:0] b0, b1, b2, logic [30:0] rb);
    sphere_pair_t p;
    p.c1 = '{a0, a1, a2};
    p.r1 = ra;
    p.c2 = '{b0, b1, b2};
    p.r2 = rb;
    pending_pairs.push_back(p);
  endtask

  task automatic add_random(int n);
    int mode;
    logic [31:0] a [3];
    logic [31:0] b [3];
    logic [30:0] ra, rb;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(2);
      for (int i = 0; i < 3; i++) begin
        a[i] = rand_coord(mode);
        b[i] = ($urandom_range(3) == 0) ? a[i] : rand_coord(mode);
      end
      case ($urandom_range(3))
        0: begin ra = 31'($urandom); rb = 31'($urandom); end
        1: begin
          ra = 31'($urandom_range(20000000));
          rb = 31'($urandom_range(20000000));
        end
        2: begin ra = 31'($urandom_range(300)) << 16; rb = 31'($urandom_range(300)) << 16; end
        default: begin ra = 31'($urandom_range(3)); rb = 31'($urandom_range(3)); end
      endcase
      add_pair(a[0], a[1], a[2], ra, b[0], b[1], b[2], rb);
    end
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || in_tvalid || merged_expected.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(32'h10000, 0, 0, 31'h10000, 32'h10000, 0, 0, 31'h10000);
    add_pair(0, 0, 0, 31'h10000, 0, 0, 0, 31'h20000);
    add_pair(0, 0, 0, 31'h50000, 32'h10000, 0, 0, 31'h10000);
    add_pair(0, 0, 0, 31'h10000, 32'h30000, 32'h40000, 0, 31'h10000);
    add_pair(0, 0, 0, 0, 0, 0, 32'h1, 0);
    add_pair(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    add_pair(32'h80000000, 32'h80000000, 32'h80000000, 0,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    add_pair(32'h7fffffff, 32'h80000000, 0, 31'h7fffffff,
             32'h80000000, 32'h7fffffff, 0, 0);
    add_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff,
             32'h0, 32'h0, 32'h0, 31'h7fffffff);
    add_pair(32'h7fffffff, 0, 32'h80000000, 0, 32'h80000000, 0, 32'h7fffffff, 31'h7fffffff);
    add_pair(0, 32'hfffe0000, 0, 31'h30000, 0, 32'h20000, 0, 31'h10000);
    add_pair(0, 0, 0, 1, 0, 0, 32'hffffffff, 2);
    add_pair(32'h12345678, 32'hedcba987, 32'h0f0f0f0f, 31'h55555555,
             32'hedcba987, 32'h12345678, 32'hf0f0f0f0, 31'h2aaaaaaa);
    add_random(10);
    wait_drained();
    repeat (80) @(posedge clk);

    add_random(110);
    wait_drained();
    send_idle_pct = 74;
    add_random(110);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 74;
    add_random(110);
    wait_drained();
    send_idle_pct = 22;
    recv_stall_pct = 22;
    add_random(110);
    wait_drained();
    recv_stall_pct = 0;
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("sphere_merge_test passed");
    end else begin
      $display("sphere_merge_test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("sphere_merge_test failed");
    $finish;
  end

endmodule
`default_nettype wire
